// ----- rtl/element_to_double_convert_core_assert.svh -----
// Assertion macros used by the converter top level.
`ifndef ELEMENT_TO_DOUBLE_CONVERT_CORE_ASSERT_SVH
`define ELEMENT_TO_DOUBLE_CONVERT_CORE_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define ETD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication outside reset.
`define ETD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ----- rtl/etd_pkg.sv -----
// Shared types, codes and helpers for the element-to-double converter.
package etd_pkg;
    localparam int unsigned WordW = 64;
    localparam int unsigned TypeW = 3;
    localparam int unsigned AddrW = 2;

    typedef enum logic [TypeW-1:0] {
        ET_F64 = 3'd0,
        ET_F32 = 3'd1,
        ET_F16 = 3'd2,
        ET_I32 = 3'd3,
        ET_U8  = 3'd4
    } t_elem_type;

    localparam logic [AddrW-1:0] RegElemType = 2'd0;

    localparam logic [63:0] ExpAll   = 64'h7FF0_0000_0000_0000;
    localparam logic [63:0] QuietBit = 64'h0008_0000_0000_0000;

    // Index of the highest set bit of a 32-bit magnitude (0 when zero).
    function automatic logic [4:0] f_msb32(input logic [31:0] v);
        logic [4:0] p;
        p = 5'd0;
        for (int i = 0; i < 32; i++) begin
            if (v[i]) begin
                p = 5'(i);
            end
        end
        return p;
    endfunction

    // Pack sign * mag * 2^scale into binary64; mag nonzero path normal result.
    function automatic logic [63:0] f_pack(input logic s, input logic [31:0] mag,
                                           input logic signed [11:0] scale);
        logic [4:0]  top;
        logic [11:0] bexp;
        logic [51:0] frac;
        logic [83:0] sh;
        top  = f_msb32(mag);
        bexp = 12'($signed({7'd0, top}) + scale + 12'sd1023);
        sh   = {52'd0, mag} << (6'd52 - {1'b0, top});
        frac = sh[51:0];
        if (mag == 32'd0) begin
            return {s, 63'd0};
        end
        return {s, bexp[10:0], frac};
    endfunction
endpackage

// ----- rtl/etd_stream_if.sv -----
// Valid/ready stream channel carrying one 64-bit word.
interface etd_stream_if;
    logic        valid;
    logic        ready;
    logic [63:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/etd_cfg_regs.sv -----
// APB-style register block holding the element type.
module etd_cfg_regs import etd_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [AddrW-1:0] paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output logic [TypeW-1:0] o_elem_type
);
    logic [TypeW-1:0] r_type;
    logic             wr;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_type <= TypeW'(ET_F64);
        end else if (wr && paddr == RegElemType) begin
            r_type <= pwdata[TypeW-1:0];
        end
    end

    always_comb begin
        prdata = 32'd0;
        if (paddr == RegElemType) begin
            prdata = {29'd0, r_type};
        end
    end

    assign o_elem_type = r_type;
endmodule

// ----- rtl/etd_convert.sv -----
// Combinational conversion of one raw element to binary64 bits.
module etd_convert import etd_pkg::*; (
    input  logic [TypeW-1:0] i_type,
    input  logic [63:0]      i_raw,
    output logic [63:0]      o_bits
);
    logic        hs, ss, is;
    logic [4:0]  he;
    logic [9:0]  hm;
    logic [7:0]  se;
    logic [22:0] sm;
    logic [31:0] imag;
    logic [63:0] half_bits, single_bits;

    always_comb begin
        hs = i_raw[15];
        he = i_raw[14:10];
        hm = i_raw[9:0];
        if (he == 5'd0) begin
            half_bits = f_pack(hs, {22'd0, hm}, -12'sd24);
        end else if (he == 5'h1F) begin
            half_bits = {hs, 63'd0} | ExpAll | ((hm != 10'd0) ? QuietBit : 64'd0);
        end else begin
            half_bits = f_pack(hs, {21'd0, 1'b1, hm}, $signed({7'd0, he}) - 12'sd25);
        end

        ss = i_raw[31];
        se = i_raw[30:23];
        sm = i_raw[22:0];
        if (se == 8'd0) begin
            single_bits = f_pack(ss, {9'd0, sm}, -12'sd149);
        end else if (se == 8'hFF) begin
            single_bits = {ss, 63'd0} | ExpAll;
            if (sm != 23'd0) begin
                single_bits = single_bits | QuietBit | {12'd0, sm, 29'd0};
            end
        end else begin
            single_bits = f_pack(ss, {8'd0, 1'b1, sm}, $signed({4'd0, se}) - 12'sd150);
        end

        is   = i_raw[31];
        imag = is ? (~i_raw[31:0] + 32'd1) : i_raw[31:0];

        case (i_type)
            ET_F64:  o_bits = i_raw;
            ET_F32:  o_bits = single_bits;
            ET_F16:  o_bits = half_bits;
            ET_I32:  o_bits = f_pack(is, imag, 12'sd0);
            ET_U8:   o_bits = f_pack(1'b0, {24'd0, i_raw[7:0]}, 12'sd0);
            default: o_bits = 64'd0;
        endcase
    end
endmodule

// ----- rtl/element_to_double_convert_core.sv -----
// Top level: APB type register, input register, converter, output skid stage.
// Converts one input element per clock to binary64 bits while the skid entry
// is free; the element passes through the input register, the single-pass
// convert logic and the result register. A two-entry output stage absorbs
// the beat in flight when the sink stalls; while its second entry is
// occupied the input is held. Change element_type only while idle.
`include "element_to_double_convert_core_assert.svh"
module element_to_double_convert_core import etd_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    etd_stream_if.sink       s_in,
    etd_stream_if.source     m_out,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [AddrW-1:0] paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    logic [TypeW-1:0] elem_type;
    logic [63:0]      conv;
    logic             r_iv;
    logic [63:0]      r_iw;
    logic             r_ov, r_sv;
    logic [63:0]      r_od, r_sd;
    logic             adv;

    etd_cfg_regs u_cfg (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready), .o_elem_type(elem_type)
    );

    etd_convert u_conv (.i_type(elem_type), .i_raw(r_iw), .o_bits(conv));

    // Advance the input stage when the skid entry is free.
    assign adv        = !r_sv;
    assign s_in.ready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv <= 1'b0;
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else begin
            if (adv) begin
                r_iv <= s_in.valid;
            end
            // Output register and skid entry.
            if (!r_ov || m_out.ready) begin
                if (r_sv) begin
                    r_ov <= 1'b1;
                    r_sv <= 1'b0;
                end else begin
                    r_ov <= r_iv && adv;
                end
            end else if (r_iv && adv) begin
                r_sv <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_iw <= s_in.data;
        end
        if (!r_ov || m_out.ready) begin
            r_od <= r_sv ? r_sd : conv;
        end else if (r_iv && adv) begin
            r_sd <= conv;
        end
    end

    assign m_out.valid = r_ov;
    assign m_out.data  = r_od;

    `ETD_ASSERT_IMP(a_skid_needs_out, i_clk, i_rst_n, r_sv, r_ov,
        "skid entry full while output empty")
    `ETD_ASSERT_NXT(a_hold_stall, i_clk, i_rst_n, r_ov && !m_out.ready,
        r_ov && $stable(r_od), "stalled result changed")
    `ETD_ASSERT_IMP(a_no_accept_full, i_clk, i_rst_n, r_sv, !s_in.ready,
        "input accepted with skid full")
endmodule
